@@ src/pcc_pkg.sv @@
// Package with shared types and constants for the clamped PID controller.
`default_nettype none

package pcc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_P           = 3'd0,
    CFG_GAIN_I           = 3'd1,
    CFG_GAIN_D           = 3'd2,
    CFG_OUT_LIMIT        = 3'd3,
    CFG_INTEGRATE_ENABLE = 3'd4,
    CFG_NEGATE_OUTPUT    = 3'd5,
    CFG_FLOOR_AT_ZERO    = 3'd6
  } cfg_reg_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Reset value of the output magnitude limit.
  localparam logic [14:0] OutLimitReset = 15'd5000;

  // One input item.
  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] setpoint;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic signed [15:0] drive;
    logic               clamped;
  } result_t;

endpackage

`default_nettype wire

@@ src/pid_controller_clamped_unit.sv @@
// Clamped discrete PID controller: error tracking, gain products and output clamp.
// An accepted item passes through the stage 1, stage 2 and result registers to the output.
// Throughput: one item per cycle; the three-stage pipeline moves as one and
// holds while a finished result is not taken.
// The error state is updated in the first stage, so each item sees the last one's error.
// Reset clears the pipeline, error state and sum; gains reset to 0, limit to 5000,
// integration on, negation and floor mode off. Configuration is always ready.
`default_nettype none

module pid_controller_clamped_unit
  import pcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     sample_valid,
  output      logic                     sample_ready,
  input  wire sample_t                  sample,
  output      logic                     result_valid,
  input  wire logic                     result_ready,
  output      result_t                  result,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  // Configuration registers.
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic        [14:0] out_limit;
  logic               integrate_enable;
  logic               negate_output;
  logic               floor_at_zero;

  // Controller state.
  logic signed [16:0] last_error;
  logic signed [31:0] error_sum;

  // Pipeline registers.
  logic               v1;
  logic               v2;
  logic signed [16:0] s1_err;
  logic signed [17:0] s1_diff;
  logic signed [31:0] s1_sum;
  logic               s1_integ;
  logic signed [32:0] s2_prod_p;
  logic signed [33:0] s2_prod_d;
  logic signed [47:0] s2_prod_i;

  // Combinational values.
  logic               advance;
  logic               accept;
  logic signed [16:0] err_in;
  logic signed [17:0] diff_in;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_next;
  logic signed [32:0] prod_p_next;
  logic signed [33:0] prod_d_next;
  logic signed [47:0] prod_i_next;
  logic signed [49:0] acc;
  logic signed [41:0] acc_shift;
  logic signed [41:0] hi;
  logic signed [41:0] lo;
  logic signed [15:0] clamp_val;
  logic               hit;
  result_t            result_next;

  // The whole pipeline moves unless a finished result waits.
  assign advance      = !result_valid || result_ready;
  assign sample_ready = !rst && advance;
  assign accept       = sample_valid && sample_ready;
  assign cfg_ready    = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      out_limit        <= OutLimitReset;
      integrate_enable <= 1'b1;
      negate_output    <= 1'b0;
      floor_at_zero    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GAIN_P:           gain_p           <= $signed(cfg_data);
        CFG_GAIN_I:           gain_i           <= $signed(cfg_data);
        CFG_GAIN_D:           gain_d           <= $signed(cfg_data);
        CFG_OUT_LIMIT:        out_limit        <= cfg_data[14:0];
        CFG_INTEGRATE_ENABLE: integrate_enable <= cfg_data[0];
        CFG_NEGATE_OUTPUT:    negate_output    <= cfg_data[0];
        CFG_FLOOR_AT_ZERO:    floor_at_zero    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1 logic: error, difference and saturating error sum.
  always_comb begin
    err_in   = 17'(sample.setpoint) - 17'(sample.measured);
    diff_in  = 18'(err_in) - 18'(last_error);
    sum_wide = 33'(error_sum) + 33'(err_in);
    if (sum_wide[32] != sum_wide[31]) begin
      sum_next = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      sum_next = sum_wide[31:0];
    end
  end

  // Controller state updates once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (accept) begin
      last_error <= err_in;
      if (integrate_enable) begin
        error_sum <= sum_next;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= accept;
      v2           <= v1;
      result_valid <= v2;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err   <= err_in;
      s1_diff  <= diff_in;
      s1_sum   <= integrate_enable ? sum_next : error_sum;
      s1_integ <= integrate_enable;
    end
  end

  // Stage 2: the three gain products.
  always_comb begin
    prod_p_next = s1_err * gain_p;
    prod_d_next = s1_diff * gain_d;
    prod_i_next = s1_integ ? (s1_sum * gain_i) : 48'sd0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_p <= prod_p_next;
      s2_prod_d <= prod_d_next;
      s2_prod_i <= prod_i_next;
    end
  end

  // Stage 3: sum, floor shift by 8, clamp and optional negation.
  always_comb begin
    acc       = 50'(s2_prod_p) + 50'(s2_prod_d) + 50'(s2_prod_i);
    acc_shift = acc[49:8];
    hi        = $signed({27'd0, out_limit});
    lo        = floor_at_zero ? '0 : -hi;
    hit       = 1'b0;
    if (acc_shift > hi) begin
      clamp_val = hi[15:0];
      hit       = 1'b1;
    end else if (acc_shift < lo) begin
      clamp_val = lo[15:0];
      hit       = 1'b1;
    end else begin
      clamp_val = acc_shift[15:0];
    end
    result_next.drive   = negate_output ? -clamp_val : clamp_val;
    result_next.clamped = hit;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // The kept error is the error of the item just taken.
  a_last_error: assert property (@(posedge clk) disable iff (rst)
    accept |=> last_error == $past(err_in))
    else $error("last_error does not match the previous item's error");

  // With integration off, the error sum holds.
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !integrate_enable) |=> $stable(error_sum))
    else $error("error sum changed with integration disabled");

  // A non-negative error never lowers the sum, also at saturation.
  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    (accept && integrate_enable && !err_in[16]) |=> error_sum >= $past(error_sum))
    else $error("error sum decreased on a non-negative error");

endmodule

`default_nettype wire
